// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers clocked on aclk, disabled while aresetn is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define KMH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define KMH_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define KMH_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KMH_ASSERT(lbl, prop, msg)
`define KMH_ASSERT_IMP(lbl, ante, cons, msg)
`define KMH_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/kmh_pkg.sv -----
// ----------------------------------------------------------------------------
// kmh_pkg
// shared constants, types and base decoding for the k-mer hash histogram
// ----------------------------------------------------------------------------
`default_nettype none

package kmh_pkg;

    localparam int KMER_LEN   = 8;
    localparam int COUNT_BITS = 32;
    localparam int WIN_W      = 2 * KMER_LEN;
    localparam int RUN_W      = $clog2(KMER_LEN + 1);
    localparam int HASH_W     = 16;
    localparam int HIST_AW    = 16;
    localparam int BIN_W      = 32;
    localparam int CHAR_W     = 8;

    localparam logic [HIST_AW-1:0]    HIST_LAST_ADDR = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX      = '1;

    localparam logic [CHAR_W-1:0] CH_A_UP = 8'h41;
    localparam logic [CHAR_W-1:0] CH_A_LO = 8'h61;
    localparam logic [CHAR_W-1:0] CH_C_UP = 8'h43;
    localparam logic [CHAR_W-1:0] CH_C_LO = 8'h63;
    localparam logic [CHAR_W-1:0] CH_G_UP = 8'h47;
    localparam logic [CHAR_W-1:0] CH_G_LO = 8'h67;
    localparam logic [CHAR_W-1:0] CH_T_UP = 8'h54;
    localparam logic [CHAR_W-1:0] CH_T_LO = 8'h74;
    localparam logic [CHAR_W-1:0] CH_N_UP = 8'h4E;
    localparam logic [CHAR_W-1:0] CH_N_LO = 8'h6E;
    localparam logic [CHAR_W-1:0] CH_STAR = 8'h2A;

    localparam logic [1:0] CODE_A = 2'd0;
    localparam logic [1:0] CODE_C = 2'd1;
    localparam logic [1:0] CODE_G = 2'd2;
    localparam logic [1:0] CODE_T = 2'd3;

    typedef enum logic {
        KIND_BASE = 1'b0,
        KIND_READ = 1'b1
    } kind_t;

    typedef struct packed {
        logic       is_base;
        logic       is_bad;
        logic [1:0] code;
    } base_dec_t;

    typedef struct packed {
        logic              hash_valid;
        logic [HASH_W-1:0] hash_value;
        logic              bad_base;
    } hash_info_t;

    typedef struct packed {
        logic               valid;
        logic               incr;
        logic [HIST_AW-1:0] addr;
    } mem_req_t;

    typedef struct packed {
        logic              hash_valid;
        logic [HASH_W-1:0] hash_value;
        logic              bad_base;
        logic [BIN_W-1:0]  bin_count;
    } result_t;

    function automatic base_dec_t decode_base(input logic [CHAR_W-1:0] ch);
        base_dec_t d;
        d = '0;
        case (ch)
            CH_A_UP, CH_A_LO: begin
                d.is_base = 1'b1;
                d.code    = CODE_A;
            end
            CH_C_UP, CH_C_LO: begin
                d.is_base = 1'b1;
                d.code    = CODE_C;
            end
            CH_G_UP, CH_G_LO: begin
                d.is_base = 1'b1;
                d.code    = CODE_G;
            end
            CH_T_UP, CH_T_LO: begin
                d.is_base = 1'b1;
                d.code    = CODE_T;
            end
            CH_N_UP, CH_N_LO, CH_STAR: begin
                d.is_base = 1'b0;
            end
            default: begin
                d.is_bad = 1'b1;
            end
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/kmer_hash_histogram_unit.sv -----
// Path: an accepted item is registered in the s1 stage, then queued in the output FIFO
// that drives the m_ channel. Throughput: one item per cycle while s_ready is high; the
// histogram update is a registered memory read followed by a write-back, with the
// previous write forwarded to the next read. Reset: window and run counter clear at
// once; all 65536 bins are cleared one per cycle, during which s_ready stays low.
// ----------------------------------------------------------------------------
// kmer_hash_histogram_unit
// 2-bit dna k-mer hashing with a saturating per-hash count histogram
// ----------------------------------------------------------------------------
`default_nettype none

module kmer_hash_histogram_unit (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic                        s_kind,
    input  wire logic [kmh_pkg::CHAR_W-1:0]  s_base_char,
    input  wire logic                        s_last_base,
    input  wire logic [kmh_pkg::HIST_AW-1:0] s_bin_index,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic                             m_hash_valid,
    output logic [kmh_pkg::HASH_W-1:0]       m_hash_value,
    output logic                             m_bad_base,
    output logic [kmh_pkg::BIN_W-1:0]        m_bin_count
);

    import kmh_pkg::*;

    logic                  accept;
    logic                  is_read;
    hash_info_t            info;
    mem_req_t              req;
    logic [COUNT_BITS-1:0] rd_count;
    logic                  clr_busy;

    logic                  s1_valid_reg;
    logic                  s1_read_reg;
    hash_info_t            s1_info_reg;

    result_t               res;
    result_t               head;
    logic                  pop;
    logic                  fifo_ne;
    logic [1:0]            fifo_cnt;
    logic [1:0]            occ;

    always_comb begin
        is_read = (s_kind == KIND_READ);
        pop     = fifo_ne && m_ready;
        occ     = 2'(fifo_cnt + {1'b0, s1_valid_reg});
        s_ready = !clr_busy && ((occ < 2'd2) || ((occ == 2'd2) && pop));
        accept  = s_valid && s_ready;

        req.valid = accept;
        req.incr  = !is_read && info.hash_valid;
        req.addr  = is_read ? s_bin_index : info.hash_value;
    end

    kmh_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (accept && !is_read),
        .base_char (s_base_char),
        .last_base (s_last_base),
        .info      (info)
    );

    kmh_hist_mem u_hist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (req),
        .rd_count (rd_count),
        .busy     (clr_busy)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        s1_read_reg <= is_read;
        s1_info_reg <= is_read ? hash_info_t'('0) : info;
    end

    always_comb begin
        res.hash_valid = s1_info_reg.hash_valid;
        res.hash_value = s1_info_reg.hash_value;
        res.bad_base   = s1_info_reg.bad_base;
        res.bin_count  = s1_read_reg ? BIN_W'(rd_count) : '0;
    end

    kmh_out_fifo u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s1_valid_reg),
        .push_data (res),
        .pop       (pop),
        .head      (head),
        .not_empty (fifo_ne),
        .count     (fifo_cnt)
    );

    always_comb begin
        m_valid      = fifo_ne;
        m_hash_valid = head.hash_valid;
        m_hash_value = head.hash_value;
        m_bad_base   = head.bad_base;
        m_bin_count  = head.bin_count;
    end

endmodule

`default_nettype wire

// ----- rtl/kmh_window.sv -----
// ----------------------------------------------------------------------------
// kmh_window
// 2-bit base window and valid-run counter, emits the k-mer hash
// ----------------------------------------------------------------------------
`default_nettype none

module kmh_window (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       step,
    input  wire logic [kmh_pkg::CHAR_W-1:0] base_char,
    input  wire logic                       last_base,
    output kmh_pkg::hash_info_t             info
);

    import kmh_pkg::*;

    logic [WIN_W-1:0] window_reg, window_next;
    logic [RUN_W-1:0] run_reg, run_next;
    logic [WIN_W-1:0] win_upd;
    logic [RUN_W-1:0] run_upd;
    base_dec_t        dec;

    always_comb begin
        dec     = decode_base(base_char);
        win_upd = '0;
        run_upd = '0;
        if (dec.is_base) begin
            win_upd = {window_reg[WIN_W-3:0], dec.code};
            run_upd = (run_reg < RUN_W'(KMER_LEN)) ? RUN_W'(run_reg + 1'b1) : run_reg;
        end
        info.hash_valid = dec.is_base && (run_upd == RUN_W'(KMER_LEN));
        info.hash_value = info.hash_valid ? HASH_W'(win_upd) : '0;
        info.bad_base   = dec.is_bad;
    end

    always_comb begin
        window_next = window_reg;
        run_next    = run_reg;
        if (step) begin
            window_next = last_base ? '0 : win_upd;
            run_next    = last_base ? '0 : run_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
            run_reg    <= '0;
        end else begin
            window_reg <= window_next;
            run_reg    <= run_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/kmh_hist_mem.sv -----
// ----------------------------------------------------------------------------
// kmh_hist_mem
// histogram memory with clearing pass, saturating read-modify-write and
// write-to-read forwarding
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module kmh_hist_mem (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire kmh_pkg::mem_req_t              req,
    output logic [kmh_pkg::COUNT_BITS-1:0]      rd_count,
    output logic                                busy
);

    import kmh_pkg::*;

    localparam int DEPTH = 2 ** HIST_AW;

    logic [COUNT_BITS-1:0] mem [DEPTH];
    logic [COUNT_BITS-1:0] rd_data_reg;

    logic                  clr_busy_reg, clr_busy_next;
    logic [HIST_AW-1:0]    clr_addr_reg, clr_addr_next;
    logic                  p1_incr_reg;
    logic [HIST_AW-1:0]    p1_addr_reg;
    logic                  last_we_reg;
    logic [HIST_AW-1:0]    last_addr_reg;
    logic [COUNT_BITS-1:0] last_data_reg;

    logic                  we;
    logic [HIST_AW-1:0]    wa;
    logic [COUNT_BITS-1:0] wd;
    logic [COUNT_BITS-1:0] inc_val;

    // forward the write that landed on the same edge as this read
    always_comb begin
        rd_count = (last_we_reg && (last_addr_reg == p1_addr_reg)) ? last_data_reg
                                                                   : rd_data_reg;
        inc_val  = (rd_count == COUNT_MAX) ? rd_count : COUNT_BITS'(rd_count + 1'b1);
        we       = clr_busy_reg || p1_incr_reg;
        wa       = clr_busy_reg ? clr_addr_reg : p1_addr_reg;
        wd       = clr_busy_reg ? '0 : inc_val;
        busy     = clr_busy_reg;
    end

    always_comb begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg) begin
            clr_addr_next = HIST_AW'(clr_addr_reg + 1'b1);
            if (clr_addr_reg == HIST_LAST_ADDR) begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rd_data_reg <= mem[req.addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            p1_incr_reg  <= 1'b0;
            last_we_reg  <= 1'b0;
        end else begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
            p1_incr_reg  <= req.valid && req.incr;
            last_we_reg  <= we;
        end
    end

    always_ff @(posedge aclk) begin
        p1_addr_reg   <= req.addr;
        last_addr_reg <= wa;
        last_data_reg <= wd;
    end

    `KMH_ASSERT_IMP(a_no_req_in_clear, clr_busy_reg, !req.valid, "item during clearing pass")
    `KMH_ASSERT_IMP(a_no_incr_in_clear, clr_busy_reg, !p1_incr_reg, "increment during clear")
    `KMH_ASSERT_IMP(a_incr_monotone, p1_incr_reg, wd >= rd_count, "count went down")
    `KMH_ASSERT_NXT(a_write_tracked, p1_incr_reg, last_we_reg && last_data_reg == $past(wd),
        "forwarding register missed a write")
    `KMH_ASSERT_IMP(a_clear_done, $fell(clr_busy_reg), $past(clr_addr_reg) == HIST_LAST_ADDR,
        "clearing pass ended early")

endmodule

`default_nettype wire

// ----- rtl/kmh_out_fifo.sv -----
// ----------------------------------------------------------------------------
// kmh_out_fifo
// two-entry result queue between the pipeline and the result channel
// ----------------------------------------------------------------------------
`default_nettype none

module kmh_out_fifo (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire kmh_pkg::result_t push_data,
    input  wire logic         pop,
    output kmh_pkg::result_t  head,
    output logic              not_empty,
    output logic [1:0]        count
);

    import kmh_pkg::*;

    result_t    buf_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = 2'(cnt_reg + {1'b0, push} - {1'b0, pop});
        head        = buf_reg[rd_ptr_reg];
        not_empty   = (cnt_reg != 2'd0);
        count       = cnt_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire
